// ----- hw/rtl/sh24_pkg.sv -----
// Shared types, constants and the SipRound function for the SipHash-2-4 stream block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sh24_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [7:0]  FIN_XOR = 8'hff;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic [63:0] word;
    logic [55:0] tail;
    logic [2:0]  add_bytes;
    logic        has_word;
    logic        last;
  } job_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t s);
    lanes_t r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    a = s.v0 + s.v1;
    b = rotl64(s.v1, 13) ^ a;
    a = rotl64(a, 32);
    c = s.v2 + s.v3;
    d = rotl64(s.v3, 16) ^ c;
    a = a + d;
    d = rotl64(d, 21) ^ a;
    c = c + b;
    b = rotl64(b, 17) ^ c;
    c = rotl64(c, 32);
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

endpackage

// ----- hw/rtl/sh24_front.sv -----
// Input side: accepts message words and turns each into a compression job.
// Depends on sh24_pkg for the job type.
`timescale 1ns / 1ps

module sh24_front import sh24_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] msg_word,
  input  logic [3:0]  word_bytes,
  input  logic        is_last,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  logic [55:0] mask;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      mask[8*i +: 8] = (word_bytes > 4'(i)) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    job.word      = msg_word;
    job.last      = is_last;
    job.has_word  = !is_last || word_bytes[3];
    job.tail      = job.has_word ? 56'd0 : (msg_word[55:0] & mask);
    job.add_bytes = job.has_word ? 3'd0 : word_bytes[2:0];
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push while queue full");
`endif

endmodule

// ----- hw/rtl/sh24_queue.sv -----
// Short job queue between the front and the round engine.
// Depends on sh24_pkg for the job type.
`timescale 1ns / 1ps

module sh24_queue import sh24_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic head_valid,
  output logic full
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == DEPTH_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/sh24_core.sv -----
// Round engine: one SipRound per cycle unless a finished hash waits on out_stall, plus the hash output register.
// Depends on sh24_pkg for lanes, job type, constants and the round function.
`timescale 1ns / 1ps

module sh24_core import sh24_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  job_t        q_head,
  input  logic        q_valid,
  output logic        pop,
  output logic [63:0] hash_value,
  output logic        out_valid,
  input  logic        out_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W0,
    ST_W1,
    ST_B0,
    ST_B1,
    ST_F
  } state_t;

  state_t      state;
  state_t      state_next;
  state_t      start_state;
  logic [1:0]  fcnt;
  logic        mid_message;
  logic [7:0]  length_low_byte;
  lanes_t      lanes;
  lanes_t      lanes_next;
  lanes_t      init;
  lanes_t      src;
  lanes_t      rin;
  lanes_t      rout;
  job_t        job;
  logic [7:0]  len_base;
  logic [7:0]  len_fin;
  logic        adv;
  logic        at_end;
  logic        fin_step;

  always_comb begin
    init.v0  = SIP_C0 ^ key_low;
    init.v1  = SIP_C1 ^ key_high;
    init.v2  = SIP_C2 ^ key_low;
    init.v3  = SIP_C3 ^ key_high;
    src      = mid_message ? lanes : init;
    len_base = mid_message ? length_low_byte : 8'd0;
    len_fin  = len_base + {5'd0, job.add_bytes};

    fin_step = (state == ST_F) && (fcnt == 2'd3);
    adv      = !(fin_step && out_valid && out_stall);
    at_end   = (state == ST_IDLE) || (state == ST_W1 && !job.last) || fin_step;
    pop      = adv && at_end && q_valid;
    start_state = q_head.has_word ? ST_W0 : ST_B0;

    rin = lanes;
    case (state)
      ST_W0: begin
        rin = src;
        rin.v3 = src.v3 ^ job.word;
      end
      ST_B0: begin
        rin = src;
        rin.v3 = src.v3 ^ {len_fin, job.tail};
      end
      default: rin = lanes;
    endcase
    rout = sip_round(rin);

    lanes_next = rout;
    case (state)
      ST_W1: lanes_next.v0 = rout.v0 ^ job.word;
      ST_B1: begin
        lanes_next.v0 = rout.v0 ^ {length_low_byte, job.tail};
        lanes_next.v2 = rout.v2 ^ {56'd0, FIN_XOR};
      end
      default: lanes_next = rout;
    endcase

    state_next = state;
    case (state)
      ST_IDLE: state_next = pop ? start_state : ST_IDLE;
      ST_W0:   state_next = ST_W1;
      ST_W1: begin
        if (job.last) begin
          state_next = ST_B0;
        end else begin
          state_next = pop ? start_state : ST_IDLE;
        end
      end
      ST_B0:   state_next = ST_B1;
      ST_B1:   state_next = ST_F;
      ST_F: begin
        if (fcnt != 2'd3) begin
          state_next = ST_F;
        end else begin
          state_next = pop ? start_state : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      fcnt            <= 2'd0;
      mid_message     <= 1'b0;
      length_low_byte <= 8'd0;
      out_valid       <= 1'b0;
    end else begin
      if (fin_step && adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        state <= state_next;
        if (pop) begin
          job <= q_head;
        end
        if (state != ST_IDLE) begin
          lanes <= lanes_next;
        end
        case (state)
          ST_W0: begin
            mid_message     <= 1'b1;
            length_low_byte <= len_base + 8'd8;
          end
          ST_B0: begin
            mid_message     <= 1'b1;
            length_low_byte <= len_fin;
          end
          ST_B1: fcnt <= 2'd0;
          ST_F: begin
            fcnt <= fcnt + 2'd1;
            if (fcnt == 2'd3) begin
              hash_value      <= rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
              mid_message     <= 1'b0;
              length_low_byte <= 8'd0;
            end
          end
          default: fcnt <= fcnt;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_w_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W0) |=> (state == ST_W1))
    else $error("word compression did not take its second round");
  a_fin_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_B1) |=> (state == ST_F && fcnt == 2'd0))
    else $error("finalization did not start at round zero");
  a_msg_done: assert property (@(posedge clk) disable iff (rst)
    (fin_step && adv) |=> (out_valid && !mid_message && length_low_byte == 8'd0))
    else $error("hash emitted without closing the message");
  a_pop_at_end: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_valid && at_end))
    else $error("job taken in the middle of another job");
`endif

endmodule

// ----- hw/rtl/siphash_2_4_stream.sv -----
// SipHash-2-4 over a streamed message: one SipRound per cycle unless a finished hash waits on
// out_stall; a word that is not last runs states W0 and W1, and a last word runs B0, B1 and F
// (after W0 and W1 if it is full), set by the round engine.
// A two-entry job queue lets transactions be accepted while a hash waits to be taken.
// Synchronous active-high rst clears keys, queue, engine state and the output valid.
`timescale 1ns / 1ps

module siphash_2_4_stream import sh24_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic [63:0] msg_word,
  input  logic [3:0]  word_bytes,
  input  logic        is_last,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [63:0] hash_value,
  output logic        out_valid,
  input  logic        out_stall
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        push;
  job_t        push_job;
  job_t        q_head;
  logic        q_valid;
  logic        q_full;
  logic        pop;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_KEY_HIGH) ? key_high : key_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= 64'd0;
      key_high <= 64'd0;
    end else if (cfg_write) begin
      if (paddr[3] == REG_KEY_LOW) begin
        key_low <= pwdata;
      end else begin
        key_high <= pwdata;
      end
    end
  end

  sh24_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_word   (msg_word),
    .word_bytes (word_bytes),
    .is_last    (is_last),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  sh24_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  sh24_core u_core (
    .clk        (clk),
    .rst        (rst),
    .key_low    (key_low),
    .key_high   (key_high),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .pop        (pop),
    .hash_value (hash_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// ----- dv/siphash_2_4_stream_test.sv -----
// Self-checking testbench for siphash_2_4_stream: streams messages, predicts each SipHash-2-4
// value in a model of its own and compares every hash with the oldest expected one.
// Depends on sh24_pkg and the siphash_2_4_stream RTL.
`timescale 1ns / 1ps

module siphash_2_4_stream_test;
  import sh24_pkg::*;

  localparam logic [3:0] ADDR_KEY_LOW  = {REG_KEY_LOW, 3'b000};
  localparam logic [3:0] ADDR_KEY_HIGH = {REG_KEY_HIGH, 3'b000};
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_ITEMS   = 420;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic [63:0] msg_word = '0;
  logic [3:0]  word_bytes = '0;
  logic        is_last = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] hash_value;
  logic        out_valid;
  logic        out_stall = 1'b0;

  logic [63:0] key_lo_model = '0;
  logic [63:0] key_hi_model = '0;
  logic [63:0] lane0, lane1, lane2, lane3;
  logic [7:0]  msg_len_mod = '0;
  logic        in_message = 1'b0;
  logic [63:0] expected_hashes[$];
  logic [63:0] oldest_hash;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  siphash_2_4_stream dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .msg_word(msg_word), .word_bytes(word_bytes), .is_last(is_last),
    .in_valid(in_valid), .in_stall(in_stall),
    .hash_value(hash_value), .out_valid(out_valid), .out_stall(out_stall)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("siphash_2_4_stream_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected none, actual %h", hash_value);
        error_count++;
      end else begin
        oldest_hash = expected_hashes.pop_front();
        if (hash_value !== oldest_hash) begin
          $error("hash_value: expected %h, actual %h", oldest_hash, hash_value);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rotate_left(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  task automatic lane_round();
    lane0 = lane0 + lane1;
    lane1 = rotate_left(lane1, 13) ^ lane0;
    lane0 = rotate_left(lane0, 32);
    lane2 = lane2 + lane3;
    lane3 = rotate_left(lane3, 16) ^ lane2;
    lane0 = lane0 + lane3;
    lane3 = rotate_left(lane3, 21) ^ lane0;
    lane2 = lane2 + lane1;
    lane1 = rotate_left(lane1, 17) ^ lane2;
    lane2 = rotate_left(lane2, 32);
  endtask

  task automatic lane_compress(input logic [63:0] m);
    lane3 = lane3 ^ m;
    lane_round();
    lane_round();
    lane0 = lane0 ^ m;
  endtask

  // Folds one accepted transaction into the running hash and queues the hash on a last word.
  task automatic siphash_absorb(input logic [63:0] word, input logic [3:0] nbytes,
                                input logic last);
    logic [63:0] tail;
    tail = '0;
    if (!in_message) begin
      lane0 = SIP_C0 ^ key_lo_model;
      lane1 = SIP_C1 ^ key_hi_model;
      lane2 = SIP_C2 ^ key_lo_model;
      lane3 = SIP_C3 ^ key_hi_model;
      msg_len_mod = '0;
      in_message = 1'b1;
    end
    if (!last || nbytes >= 4'd8) begin
      lane_compress(word);
      msg_len_mod = msg_len_mod + 8'd8;
    end else begin
      if (nbytes != 0) tail = word & ({64{1'b1}} >> (64 - 8 * nbytes));
      msg_len_mod = msg_len_mod + 8'(nbytes);
    end
    if (last) begin
      lane_compress({msg_len_mod, tail[55:0]});
      lane2 = lane2 ^ 64'(FIN_XOR);
      repeat (4) lane_round();
      expected_hashes.push_back(lane0 ^ lane1 ^ lane2 ^ lane3);
      in_message = 1'b0;
      msg_len_mod = '0;
    end
  endtask

  task automatic send_word(input logic [63:0] word, input logic [3:0] nbytes, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    msg_word <= word;
    word_bytes <= nbytes;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    siphash_absorb(word, nbytes, last);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_KEY_LOW) key_lo_model = value;
    else key_hi_model = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(9))
      0: return '0;
      1: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_message();
    int unsigned nwords;
    logic [3:0] nbytes;
    nwords = ($urandom_range(14) == 0) ? $urandom_range(40, 33) : $urandom_range(5, 1);
    for (int unsigned i = 1; i < nwords; i++)
      send_word(random_word(), 4'($urandom_range(15)), 1'b0);
    nbytes = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    send_word(random_word(), nbytes, 1'b1);
  endtask

  task automatic test_message_edges();
    write_key(ADDR_KEY_LOW, '0);
    write_key(ADDR_KEY_HIGH, '0);
    send_word({64{1'b1}}, 4'd0, 1'b1);
    for (int unsigned n = 1; n <= 8; n++)
      send_word({$urandom, $urandom}, 4'(n), 1'b1);
    send_word({64{1'b1}}, 4'd9, 1'b1);
    send_word({$urandom, $urandom}, 4'd15, 1'b1);
    send_word('0, 4'd15, 1'b0);
    send_word({64{1'b1}}, 4'd0, 1'b0);
    send_word({$urandom, $urandom}, 4'd3, 1'b1);
    send_word({$urandom, $urandom}, 4'd5, 1'b0);
    send_word({$urandom, $urandom}, 4'd8, 1'b1);
    wait_drained();
    write_key(ADDR_KEY_LOW, {64{1'b1}});
    write_key(ADDR_KEY_HIGH, {64{1'b1}});
    send_word('0, 4'd0, 1'b1);
    send_word({$urandom, $urandom}, 4'd1, 1'b0);
    send_word({$urandom, $urandom}, 4'd7, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_streams();
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct <= 59;
          write_key(ADDR_KEY_LOW, {$urandom, $urandom});
          write_key(ADDR_KEY_HIGH, {$urandom, $urandom});
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct <= 29;
          write_key(ADDR_KEY_LOW, {64{1'b1}});
          write_key(ADDR_KEY_HIGH, '0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          write_key(ADDR_KEY_LOW, '0);
          write_key(ADDR_KEY_HIGH, {64{1'b1}});
        end
      endcase
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) send_random_message();
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while transactions keep coming, so the
  // job queue fills and the input stalls; then the sender pauses until all hashes are in, and resumes.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 10;
    write_key(ADDR_KEY_LOW, {$urandom, $urandom});
    write_key(ADDR_KEY_HIGH, {$urandom, $urandom});
    hold_req <= hold_req + 1;
    repeat (8) send_random_message();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (4) send_random_message();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_message_edges();
    test_random_streams();
    test_output_backpressure();
    if (error_count == 0 && expected_hashes.size() == 0) begin
      $display("siphash_2_4_stream_test: clean");
    end else begin
      $display("siphash_2_4_stream_test: errors");
    end
    $finish;
  end

endmodule
